### design/q16_pkg.sv
// Package for the Q16.16 arithmetic unit: operation codes, widths and the
// request and result structures shared by the front end, queue and back end.
// Depends on nothing.
package q16_pkg;
	localparam int DataW = 32;
	localparam int FracBitsDef = 16;
	localparam int QDepthDef = 4;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_DIV = 2'd1,
		OP_F2FIX = 2'd2,
		OP_ABS = 2'd3
	} op_t;

	// Request after classification: magnitudes and sign taken apart up front.
	typedef struct packed {
		op_t op;
		logic [DataW-1:0] a;
		logic [DataW-1:0] b;
		logic [DataW-1:0] mag_a;
		logic [DataW-1:0] mag_b;
		logic neg;
		logic div_zero;
	} req_t;

	typedef struct packed {
		logic [DataW-1:0] value;
		logic err;
	} res_t;
endpackage

### design/q16_front.sv
// Front end of the Q16.16 unit: accepts requests, classifies them and forms
// operand magnitudes and result sign, registered into one stage.
// Depends on q16_pkg.
module q16_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] req_type,
	input logic signed [q16_pkg::DataW-1:0] operand_a,
	input logic signed [q16_pkg::DataW-1:0] operand_b,
	output logic out_valid,
	input logic out_ready,
	output q16_pkg::req_t out_req
);
	import q16_pkg::*;

	logic valid_s1;
	req_t req_s1;
	req_t req_d;
	logic [DataW-1:0] ua, ub;

	assign ua = operand_a;
	assign ub = operand_b;
	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		req_d.op = op_t'(req_type);
		req_d.a = ua;
		req_d.b = ub;
		req_d.mag_a = ua[DataW-1] ? (~ua + 1'b1) : ua;
		req_d.mag_b = ub[DataW-1] ? (~ub + 1'b1) : ub;
		req_d.neg = ua[DataW-1] ^ ub[DataW-1];
		req_d.div_zero = (ub == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= req_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_req = req_s1;
endmodule

### design/q16_queue.sv
// Short queue between the front and back ends of the Q16.16 unit, so that
// either side may stall on its own. Depends on q16_pkg.
module q16_queue #(
	parameter int Depth = q16_pkg::QDepthDef
) (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input q16_pkg::req_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output q16_pkg::req_t rd_data
);
	import q16_pkg::*;

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	req_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = (cnt_q != Depth[AW:0]);
	assign rd_valid = (cnt_q != '0);
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end
endmodule

### design/q16_back.sv
// Back end of the Q16.16 unit: a pipeline with a staged multiplier, a
// one-bit-a-stage restoring divider, the float conversion and the absolute
// value, ending in an output register. Depends on q16_pkg.
module q16_back #(
	parameter int FracBits = q16_pkg::FracBitsDef
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input q16_pkg::req_t in_req,
	output logic out_valid,
	input logic out_ready,
	output q16_pkg::res_t out_res
);
	import q16_pkg::*;

	// Dividend is |a| << FracBits; one quotient bit per stage.
	localparam int NW = DataW + FracBits;
	localparam int NS = NW;
	localparam int HW = DataW / 2;

	logic adv;
	logic [NS:0] vld_q;
	op_t op_q [NS+1];
	logic neg_q [NS+1];
	logic err_q [NS+1];
	logic [DataW-1:0] fast_q [NS+1];
	logic [DataW:0] rem_q [NS+1];
	logic [NW-1:0] quo_q [NS+1];
	logic [DataW-1:0] dvs_q [NS+1];
	// Multiplier: four 16x16 partial products in stage 1, summed in stage 2.
	logic [2*DataW-1:0] pp_sum_q;
	logic [DataW-1:0] pll_q, plh_q, phl_q, phh_q;

	logic out_v_q;
	res_t out_q;

	assign adv = !out_v_q || out_ready;
	assign in_ready = adv;

	// Float to fixed and absolute value, worked out at entry.
	logic [DataW-1:0] f2fix, absv, fast_d;
	logic [7:0] ex;
	logic signed [9:0] sh;
	logic [DataW-1:0] mant, mag;
	always_comb begin
		ex = in_req.a[30:23];
		mant = {8'd0, 1'b1, in_req.a[22:0]};
		sh = $signed({2'b00, ex}) - 10'sd127 - 10'sd23 + 10'(FracBits);
		if (sh >= 0) begin
			mag = (sh >= 10'sd32) ? '0 : (mant << sh[4:0]);
		end else begin
			mag = (-sh >= 10'sd32) ? '0 : (mant >> 5'((-sh)));
		end
		f2fix = in_req.a[DataW-1] ? (~mag + 1'b1) : mag;
		absv = in_req.mag_a;
		fast_d = (in_req.op == OP_F2FIX) ? f2fix : absv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_q[0] <= in_req.op;
			neg_q[0] <= in_req.neg;
			err_q[0] <= (in_req.op == OP_DIV) && in_req.div_zero;
			fast_q[0] <= fast_d;
			rem_q[0] <= '0;
			quo_q[0] <= NW'(in_req.mag_a) << FracBits;
			dvs_q[0] <= in_req.mag_b;
			pll_q <= DataW'(in_req.a[HW-1:0]) * DataW'(in_req.b[HW-1:0]);
			plh_q <= DataW'(in_req.a[HW-1:0]) * DataW'(in_req.b[DataW-1:HW]);
			phl_q <= DataW'(in_req.a[DataW-1:HW]) * DataW'(in_req.b[HW-1:0]);
			phh_q <= DataW'(in_req.a[DataW-1:HW]) * DataW'(in_req.b[DataW-1:HW]);
			pp_sum_q <= {phh_q, pll_q} + ({32'd0, plh_q} << HW)
				+ ({32'd0, phl_q} << HW);
		end
	end

	// Restoring divider stages: quo holds remaining dividend bits then quotient.
	genvar g;
	generate
		for (g = 0; g < NS; g++) begin : g_div
			logic [DataW:0] trial;
			logic [DataW+1:0] diff;
			assign trial = {rem_q[g][DataW-1:0], quo_q[g][NW-1]};
			assign diff = {1'b0, trial} - {2'b00, dvs_q[g]};
			always_ff @(posedge clk) begin
				if (adv) begin
					op_q[g+1] <= op_q[g];
					neg_q[g+1] <= neg_q[g];
					err_q[g+1] <= err_q[g];
					fast_q[g+1] <= fast_q[g];
					dvs_q[g+1] <= dvs_q[g];
					rem_q[g+1] <= diff[DataW+1] ? trial : diff[DataW:0];
					quo_q[g+1] <= {quo_q[g][NW-2:0], !diff[DataW+1]};
				end
			end
		end
	endgenerate

	// Signed correction for the multiply is applied in stage 3, with the operand signs carried alongside.
	logic [2*DataW-1:0] sprod_q;
	logic [DataW-1:0] mres_q [NS+1];
	logic op_a_neg_q, op_b_neg_q, op_a_neg1_q, op_b_neg1_q;
	logic [DataW-1:0] a1_q, b1_q, a2_q, b2_q;
	logic [2*DataW-1:0] adj;
	always_ff @(posedge clk) begin
		if (adv) begin
			sprod_q <= pp_sum_q
				- (op_a_neg_q ? {b2_q, 32'd0} : '0)
				- (op_b_neg_q ? {a2_q, 32'd0} : '0);
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			a1_q <= in_req.a;
			b1_q <= in_req.b;
			op_a_neg1_q <= in_req.a[DataW-1];
			op_b_neg1_q <= in_req.b[DataW-1];
			a2_q <= a1_q;
			b2_q <= b1_q;
			op_a_neg_q <= op_a_neg1_q;
			op_b_neg_q <= op_b_neg1_q;
		end
	end
	assign adj = sprod_q + (sprod_q[2*DataW-1] ? ((64'd1 << FracBits) - 64'd1) : 64'd0);
	generate
		for (g = 0; g < NS; g++) begin : g_mres
			always_ff @(posedge clk) begin
				if (adv) begin
					mres_q[g+1] <= (g == 2) ? adj[FracBits +: DataW] : mres_q[g];
				end
			end
		end
	endgenerate
	always_ff @(posedge clk) begin
		if (adv) begin
			mres_q[0] <= '0;
		end
	end

	logic [DataW-1:0] dq, final_v;
	always_comb begin
		dq = quo_q[NS][DataW-1:0];
		unique case (op_q[NS])
			OP_MUL: final_v = mres_q[NS];
			OP_DIV: final_v = err_q[NS] ? '0 : (neg_q[NS] ? (~dq + 1'b1) : dq);
			default: final_v = fast_q[NS];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= vld_q[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.value <= final_v;
			out_q.err <= err_q[NS];
		end
	end

	assign out_valid = out_v_q;
	assign out_res = out_q;
endmodule

### design/q16_fixed_point_alu.sv
// Top level of the Q16.16 arithmetic unit: a front end, a short queue and
// a pipelined back end. Depends on q16_pkg, q16_front, q16_queue, q16_back.
//
// One request in, one result out, in order. A new request is taken every
// cycle while full is low; the latency of each result is set by the
// restoring divider, which retires one quotient bit per stage over 48
// stages. Every operation runs through the same pipeline.
module q16_fixed_point_alu #(
	parameter int FRAC_BITS = q16_pkg::FracBitsDef,
	parameter int QDepth = q16_pkg::QDepthDef
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [1:0] req_type,
	input logic signed [q16_pkg::DataW-1:0] operand_a,
	input logic signed [q16_pkg::DataW-1:0] operand_b,
	output logic empty,
	input logic pop,
	output logic signed [q16_pkg::DataW-1:0] result,
	output logic status
);
	import q16_pkg::*;

	logic f_ready, f_valid, q_ready, q_valid, b_ready, b_valid;
	req_t f_req, q_req;
	res_t b_res;

	q16_front u_front (
		.clk, .arst_n,
		.in_valid(push), .in_ready(f_ready),
		.req_type, .operand_a, .operand_b,
		.out_valid(f_valid), .out_ready(q_ready), .out_req(f_req)
	);

	q16_queue #(.Depth(QDepth)) u_queue (
		.clk, .arst_n,
		.wr_valid(f_valid), .wr_ready(q_ready), .wr_data(f_req),
		.rd_valid(q_valid), .rd_ready(b_ready), .rd_data(q_req)
	);

	q16_back #(.FracBits(FRAC_BITS)) u_back (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(b_ready), .in_req(q_req),
		.out_valid(b_valid), .out_ready(pop), .out_res(b_res)
	);

	assign full = !f_ready;
	assign empty = !b_valid;
	assign result = b_res.value;
	assign status = b_res.err;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status) |-> (result == '0))
		else $error("division error beat carries a non-zero result");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result) && $stable(status)))
		else $error("waiting result changed before it was taken");
endmodule
